/* sv/dctd_pkg.sv */
// Shared types, constants and calendar helpers for the day-count to date converter.
// No dependencies; every other file of the block imports this package.

package dctd_pkg;

    localparam int COUNT_WIDTH_DEF = 20;

    localparam int YEAR_W  = 13;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int LEN_W   = 9;   // holds a year length of 366
    localparam int CYC_W   = 9;   // position within the 400-year cycle

    localparam logic [YEAR_W-1:0]  BASE_YEAR    = YEAR_W'(2000);
    localparam logic [CYC_W-1:0]   CYCLE_LAST   = CYC_W'(399);
    localparam logic [CYC_W-1:0]   CENTURY_1    = CYC_W'(100);
    localparam logic [CYC_W-1:0]   CENTURY_2    = CYC_W'(200);
    localparam logic [CYC_W-1:0]   CENTURY_3    = CYC_W'(300);
    localparam logic [LEN_W-1:0]   DAYS_LEAP    = LEN_W'(366);
    localparam logic [LEN_W-1:0]   DAYS_COMMON  = LEN_W'(365);

    localparam logic [MONTH_W-1:0] JANUARY   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] APRIL     = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] JUNE      = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] SEPTEMBER = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] NOVEMBER  = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WDAY,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Selects what the shared subtractor takes off the remaining days.
    typedef struct packed {
        logic                month_phase;
        logic                leap;
        logic [MONTH_W-1:0]  month;
    } t_step_ctrl;

    // Leap year from the position in the 400-year cycle (cycle starts at year 2000).
    function automatic logic is_leap(input logic [CYC_W-1:0] cyc);
        logic century;
        century = (cyc == CENTURY_1) || (cyc == CENTURY_2) || (cyc == CENTURY_3);
        return (cyc[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [LEN_W-1:0] len;
        if ((month == APRIL) || (month == JUNE) || (month == SEPTEMBER) ||
            (month == NOVEMBER)) begin
            len = LEN_W'(30);
        end else if (month == FEBRUARY) begin
            len = leap ? LEN_W'(29) : LEN_W'(28);
        end else begin
            len = LEN_W'(31);
        end
        return len;
    endfunction

endpackage

/* sv/day_count_to_date.sv */
// Day-count to Gregorian date converter, top level with the sequencer and output register.
// Depends on dctd_pkg, dctd_step and dctd_mod7.
//
// Takes a count of days since 2000-01-01 and returns year, month, day of month and weekday
// (0 Saturday through 6 Friday). One transaction is worked on at a time: s_axis_tready is
// high only while the sequencer is idle. A conversion waits for the weekday digits to drain,
// then takes off whole years, then whole months of the final year, and then loads the output
// register; the next count can be taken in the same cycle that its date becomes valid. The
// shared compare-and-subtract unit removes one year or one month per cycle, so the year count
// dominates the conversion time. The result sits in an output register, so a finished date
// may wait on m_axis_tready while no further transaction is taken until it has been loaded
// there. Years past 8191 wrap.

module day_count_to_date
    import dctd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // day_count [COUNT_WIDTH-1:0], zero padding above
    input  logic [((COUNT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // year_value [12:0], month_value [16:13], day_of_month [21:17], weekday [24:22]
    output logic [31:0]                              m_axis_tdata
);

    t_state                 r_state, n_state;
    logic [COUNT_WIDTH-1:0] r_rest, n_rest;
    logic [YEAR_W-1:0]      r_year, n_year;
    logic [CYC_W-1:0]       r_ycyc, n_ycyc;
    logic [MONTH_W-1:0]     r_month, n_month;

    logic                   r_o_valid, n_o_valid;
    logic [YEAR_W-1:0]      r_o_year;
    logic [MONTH_W-1:0]     r_o_month;
    logic [DAY_W-1:0]       r_o_day;
    logic [WDAY_W-1:0]      r_o_wday;

    logic                   accept;
    logic                   load_out;
    t_step_ctrl             step_ctrl;
    logic                   step_ge;
    logic [COUNT_WIDTH-1:0] step_diff;
    logic [WDAY_W-1:0]      wday;
    logic                   wday_done;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Shared subtractor: year lengths in S_YEAR, month lengths in S_MONTH
    always_comb begin
        step_ctrl.month_phase = (r_state == S_MONTH);
        step_ctrl.leap        = is_leap(r_ycyc);
        step_ctrl.month       = r_month;
    end

    dctd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .i_rest (r_rest),
        .i_ctrl (step_ctrl),
        .o_ge   (step_ge),
        .o_diff (step_diff)
    );

    dctd_mod7 #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_mod7 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_count (s_axis_tdata[COUNT_WIDTH-1:0]),
        .o_wday  (wday),
        .o_done  (wday_done)
    );

    // Sequencer: next state and working registers
    always_comb begin
        n_state  = r_state;
        n_rest   = r_rest;
        n_year   = r_year;
        n_ycyc   = r_ycyc;
        n_month  = r_month;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rest  = s_axis_tdata[COUNT_WIDTH-1:0];
                    n_year  = BASE_YEAR;
                    n_ycyc  = '0;
                    n_month = JANUARY;
                    n_state = S_WDAY;
                end
            end
            S_WDAY: begin
                // wait for the weekday digits to drain
                if (wday_done) begin
                    n_state = S_YEAR;
                end
            end
            S_YEAR: begin
                // take off one whole year per cycle
                if (step_ge) begin
                    n_rest = step_diff;
                    n_year = r_year + YEAR_W'(1);
                    n_ycyc = (r_ycyc == CYCLE_LAST) ? '0 : r_ycyc + CYC_W'(1);
                end else begin
                    n_state = S_MONTH;
                end
            end
            S_MONTH: begin
                // take off one whole month per cycle, never past December
                if ((r_month != DECEMBER) && step_ge) begin
                    n_rest  = step_diff;
                    n_month = r_month + MONTH_W'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_o_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_o_valid = (r_o_valid && !m_axis_tready) || load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_year  <= n_year;
        r_ycyc  <= n_ycyc;
        r_month <= n_month;
        if (load_out) begin
            r_o_year  <= r_year;
            r_o_month <= r_month;
            r_o_day   <= DAY_W'(r_rest) + DAY_W'(1);
            r_o_wday  <= wday;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {7'd0, r_o_wday, r_o_day, r_o_month, r_o_year};

    // The month walk never leaves January to December
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MONTH) |-> ((r_month >= JANUARY) && (r_month <= DECEMBER)))
        else $error("month out of range during month walk");

    // An accepted transaction always starts the weekday digits
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ((r_state == S_WDAY) && !wday_done))
        else $error("accepted transaction did not start conversion");

    // A delivered weekday is always reduced below seven
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_o_wday <= WDAY_W'(6)))
        else $error("weekday not reduced modulo seven");

    // The 400-year cycle position stays within its cycle while years are stepped
    a_cycle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_YEAR) |-> (r_ycyc <= CYCLE_LAST))
        else $error("year cycle position out of range");

endmodule

/* sv/dctd_step.sv */
// Shared compare-and-subtract unit: takes a year or month length off the remaining days.
// Depends on dctd_pkg for the step control struct and the length helpers.

module dctd_step
    import dctd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0] i_rest,
    input  t_step_ctrl             i_ctrl,
    output logic                   o_ge,
    output logic [COUNT_WIDTH-1:0] o_diff
);

    logic [LEN_W-1:0]       len;
    logic [COUNT_WIDTH-1:0] len_ext;

    always_comb begin
        if (i_ctrl.month_phase) begin
            len = month_len(i_ctrl.month, i_ctrl.leap);
        end else begin
            len = i_ctrl.leap ? DAYS_LEAP : DAYS_COMMON;
        end
        len_ext = COUNT_WIDTH'(len);
    end

    assign o_ge   = (i_rest >= len_ext);
    assign o_diff = i_rest - len_ext;

endmodule

/* sv/dctd_mod7.sv */
// Weekday unit: count modulo 7, one octal digit per cycle (8 is 1 modulo 7).
// Depends on dctd_pkg for field widths.

module dctd_mod7
    import dctd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic [WDAY_W-1:0]      o_wday,
    output logic                   o_done
);

    localparam int NDIG  = (COUNT_WIDTH + 2) / 3;
    localparam int SH_W  = NDIG * 3;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [SH_W-1:0]   r_shift;
    logic [WDAY_W-1:0] r_acc;
    logic [CNT_W-1:0]  r_left;
    logic [WDAY_W:0]   sum;

    always_comb begin
        sum = {1'b0, r_acc} + {1'b0, r_shift[2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= CNT_W'(NDIG);
        end else if (r_left != '0) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift <= SH_W'(i_count);
            r_acc   <= '0;
        end else if (r_left != '0) begin
            r_shift <= r_shift >> 3;
            r_acc   <= (sum >= (WDAY_W+1)'(7)) ? WDAY_W'(sum - (WDAY_W+1)'(7))
                                                : WDAY_W'(sum);
        end
    end

    assign o_wday = r_acc;
    assign o_done = (r_left == '0);

endmodule

/* test/tb_day_count_to_date.sv */
// Self-checking testbench for day_count_to_date: streams day counts in, checks dates out.
// Depends on dctd_pkg and the day_count_to_date RTL; needs no other file.
`timescale 1ns / 100ps

module tb_day_count_to_date;
    import dctd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    localparam int IN_W         = ((COUNT_WIDTH_DEF + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 120;
    localparam int MAX_GAP      = 5;
    localparam int CALM_FIRST   = 60;     // transactions in this window run without idling
    localparam int CALM_LAST    = 90;
    localparam int HOLD_AT      = 30;     // dates taken before the long back-pressure stretch
    localparam int HOLD_CYCLES  = 3200;   // longer than the slowest conversion
    localparam int SETTLE       = 100;

    localparam int unsigned DAYS_PER_CYCLE = 146097;   // days in 400 Gregorian years
    localparam int unsigned COUNT_MAX      = (1 << COUNT_WIDTH_DEF) - 1;

    typedef logic [COUNT_WIDTH_DEF-1:0] t_count;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   mday;
        logic [WDAY_W-1:0]  wday;
    } t_date;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [31:0]     m_axis_tdata;

    t_count      pending_counts[$];
    t_date       expected_dates[$];
    t_date       oldest_date;
    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned items_issued = 0;
    int unsigned dates_seen = 0;
    int unsigned mismatches = 0;

    day_count_to_date #(
        .COUNT_WIDTH(COUNT_WIDTH_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // day_count [19:0], zero padding above
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // year_value [12:0], month_value [16:13], day_of_month [21:17], weekday [24:22]
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic logic leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(input int unsigned yr);
        return leap_year(yr) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
        int unsigned len;
        if (mon == APRIL || mon == JUNE || mon == SEPTEMBER || mon == NOVEMBER) begin
            len = 30;
        end else if (mon == FEBRUARY) begin
            len = leap_year(yr) ? 29 : 28;
        end else begin
            len = 31;
        end
        return len;
    endfunction

    // Work out the calendar date of a day count: strip whole 400-year cycles, then single
    // years, then months; whatever is left is the day within the month, counted from zero.
    function automatic t_date date_of_count(input t_count count);
        int unsigned rest;
        int unsigned yr;
        int unsigned mon;
        t_date d;
        rest = 32'(count);
        yr   = BASE_YEAR + 400 * (rest / DAYS_PER_CYCLE);
        rest = rest % DAYS_PER_CYCLE;
        mon  = 32'(JANUARY);
        while (rest >= days_in_year(yr)) begin
            rest = rest - days_in_year(yr);
            yr   = yr + 1;
        end
        while (mon < DECEMBER && rest >= days_in_month(mon, yr)) begin
            rest = rest - days_in_month(mon, yr);
            mon  = mon + 1;
        end
        d.year  = YEAR_W'(yr);
        d.month = MONTH_W'(mon);
        d.mday  = DAY_W'(rest + 1);
        d.wday  = WDAY_W'(count % 7);
        return d;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Sample both handshakes at the rising edge. Retire the oldest expectation before
    // queueing a new one, so a date offered in the very cycle its count goes in is caught.
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                $error("date transaction 0x%08h arrived with no conversion pending", m_axis_tdata);
                mismatches++;
            end else begin
                oldest_date = expected_dates.pop_front();
                check_field("year_value",   32'(oldest_date.year),  32'(m_axis_tdata[12:0]));
                check_field("month_value",  32'(oldest_date.month), 32'(m_axis_tdata[16:13]));
                check_field("day_of_month", 32'(oldest_date.mday),  32'(m_axis_tdata[21:17]));
                check_field("weekday",      32'(oldest_date.wday),  32'(m_axis_tdata[24:22]));
            end
            dates_seen <= dates_seen + 1;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_dates.push_back(date_of_count(s_axis_tdata[COUNT_WIDTH_DEF-1:0]));
        end
    end

    // Driver: hold an offered count until it is taken, then idle for the drawn gap
    // before offering the next one from the pending queue.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_fire) begin
            // hold the offer
        end else if (gap_left != 0) begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end else if (pending_counts.size() != 0) begin
            s_axis_tdata  <= IN_W'(pending_counts.pop_front());
            s_axis_tvalid <= 1'b1;
            gap_left      <= (items_issued >= CALM_FIRST && items_issued < CALM_LAST) ?
                             0 : $urandom_range(0, MAX_GAP);
            items_issued  <= items_issued + 1;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Long back-pressure stretch, counted here, so the block fills and stalls its input.
    always @(negedge i_clk) begin
        if (!hold_done && dates_seen == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: draw a stall for every date taken, and drop ready during the long hold.
    always @(negedge i_clk) begin
        if (out_fire) begin
            stall_left = (dates_seen >= CALM_FIRST && dates_seen < CALM_LAST) ?
                         0 : $urandom_range(0, MAX_GAP);
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
        end
        m_axis_tready <= i_rst_n && (stall_left == 0) && (hold_left == 0);
    end

    initial begin
        // Directed counts: the first day, month and year edges, the leap day of a
        // 400-divisible year, a century year that is not leap, the turn of the 400-year
        // cycle, alternating bit patterns and the largest count.
        pending_counts = '{
            t_count'(0),      t_count'(1),      t_count'(30),     t_count'(31),
            t_count'(59),     t_count'(60),     t_count'(365),    t_count'(366),
            t_count'(424),    t_count'(425),    t_count'(1826),   t_count'(36524),
            t_count'(36525),  t_count'(36583),  t_count'(36584),  t_count'(146096),
            t_count'(146097), t_count'(146156), t_count'(20'hAAAAA),
            t_count'(20'h55555), t_count'(COUNT_MAX)
        };
        // Random counts: mostly the first century or so to keep conversions short,
        // some in the first few years for dense month edges, a fifth over the full range.
        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:    pending_counts.push_back(t_count'($urandom_range(0, COUNT_MAX)));
                4, 5, 6:       pending_counts.push_back(t_count'($urandom_range(0, 1500)));
                default:       pending_counts.push_back(t_count'($urandom_range(0, 40000)));
            endcase
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every count has been taken, then until every date has come back.
        while (pending_counts.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_dates.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest correct run.
    initial begin
        #(16_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
sv/dctd_pkg.sv
sv/dctd_step.sv
sv/dctd_mod7.sv
sv/day_count_to_date.sv
test/tb_day_count_to_date.sv
